[hdl/swme_pkg.sv]
// Shared types and widths for the sliding window min/max envelope block.
package swme_pkg;

   localparam int SAMPLE_W = 32;
   localparam int POS_W    = 32;
   localparam int RAD_W    = 5;

   typedef struct packed {
      logic [POS_W-1:0]           pos;
      logic signed [SAMPLE_W-1:0] val;
   } entry_type;

   typedef struct packed {
      logic clear;
      logic push;
      logic front;
   } deque_cmd_type;

endpackage

[hdl/swme_deque.sv]
// Monotonic min deque held in a ring memory with a cached head entry and tail value.
module swme_deque import swme_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int LIM_W = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   input  deque_cmd_type              cmd,
   input  logic signed [SAMPLE_W-1:0] push_val,
   input  logic [POS_W-1:0]           push_pos,
   input  logic [POS_W-1:0]           now,
   input  logic [LIM_W-1:0]           limit,
   output logic                       busy,
   output logic signed [SAMPLE_W-1:0] head_val
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(DEPTH);

   typedef enum logic [2:0] {
      D_IDLE   = 3'b001,
      D_CMP    = 3'b010,
      D_EXPIRE = 3'b100
   } deque_state_type;

   function automatic logic [IDX_W-1:0] slot_of(logic [IDX_W-1:0] base,
                                                logic [CNT_W-1:0] off);
      logic [IDX_W:0] s;
      s = {1'b0, base} + (IDX_W + 1)'(off);
      if (s >= DEPTH_X) begin
         s = s - DEPTH_X;
      end
      return s[IDX_W-1:0];
   endfunction

   function automatic logic expired(logic [POS_W-1:0] pos, logic [POS_W-1:0] cur,
                                    logic [LIM_W-1:0] lim);
      logic [POS_W-1:0] age;
      age = cur - pos;
      return age > POS_W'(lim);
   endfunction

   entry_type ring_ff [DEPTH];
   entry_type rd_ff;

   deque_state_type            state_ff, state_in;
   logic [IDX_W-1:0]           head_ff, head_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   entry_type                  head_ent_ff, head_ent_in;
   logic                       head_ok_ff, head_ok_in;
   logic signed [SAMPLE_W-1:0] tail_ff, tail_in;
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic [POS_W-1:0]           p_ff, p_in;
   logic [POS_W-1:0]           now_ff, now_in;
   logic [LIM_W-1:0]           limit_ff, limit_in;

   logic                       rd_en, wr_en, wr_go;
   logic [IDX_W-1:0]           rd_idx, wr_idx, next_head;
   logic [CNT_W-1:0]           wr_cnt, cnt_dec;
   logic signed [SAMPLE_W-1:0] wr_x;
   logic [POS_W-1:0]           wr_p;
   entry_type                  wr_ent;

   assign next_head = slot_of(head_ff, CNT_ONE);
   assign cnt_dec   = count_ff - 1'b1;
   assign busy      = (state_ff != D_IDLE);
   assign head_val  = head_ent_ff.val;

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      head_ent_in = head_ent_ff;
      head_ok_in  = head_ok_ff;
      tail_in     = tail_ff;
      x_in        = x_ff;
      p_in        = p_ff;
      now_in      = now_ff;
      limit_in    = limit_ff;
      rd_en       = 1'b0;
      rd_idx      = head_ff;
      wr_go       = 1'b0;
      wr_cnt      = count_ff;
      wr_x        = push_val;
      wr_p        = push_pos;
      wr_en       = 1'b0;
      wr_idx      = head_ff;
      wr_ent      = '{pos: push_pos, val: push_val};

      case (state_ff)
         D_IDLE: begin
            if (cmd.clear) begin
               head_in    = '0;
               count_in   = '0;
               head_ok_in = 1'b0;
            end else if (cmd.push) begin
               x_in = push_val;
               p_in = push_pos;
               if (count_ff != '0 && tail_ff >= push_val) begin
                  count_in = cnt_dec;
                  if (cnt_dec == '0) begin
                     wr_go  = 1'b1;
                     wr_cnt = '0;
                  end else begin
                     rd_en    = 1'b1;
                     rd_idx   = slot_of(head_ff, cnt_dec - 1'b1);
                     state_in = D_CMP;
                  end
               end else begin
                  wr_go  = 1'b1;
                  wr_cnt = count_ff;
               end
            end else if (cmd.front) begin
               now_in   = now;
               limit_in = limit;
               if (!head_ok_ff) begin
                  rd_en    = 1'b1;
                  rd_idx   = head_ff;
                  state_in = D_EXPIRE;
               end else if (count_ff > CNT_ONE && expired(head_ent_ff.pos, now, limit)) begin
                  head_in  = next_head;
                  count_in = cnt_dec;
                  rd_en    = 1'b1;
                  rd_idx   = next_head;
                  state_in = D_EXPIRE;
               end
            end
         end
         D_CMP: begin
            wr_x = x_ff;
            wr_p = p_ff;
            if ($signed(rd_ff.val) >= x_ff) begin
               count_in = cnt_dec;
               if (cnt_dec == '0) begin
                  wr_go    = 1'b1;
                  wr_cnt   = '0;
                  state_in = D_IDLE;
               end else begin
                  rd_en  = 1'b1;
                  rd_idx = slot_of(head_ff, cnt_dec - 1'b1);
               end
            end else begin
               wr_go    = 1'b1;
               wr_cnt   = count_ff;
               state_in = D_IDLE;
            end
         end
         D_EXPIRE: begin
            head_ent_in = rd_ff;
            head_ok_in  = 1'b1;
            if (count_ff > CNT_ONE && expired(rd_ff.pos, now_ff, limit_ff)) begin
               head_in  = next_head;
               count_in = cnt_dec;
               rd_en    = 1'b1;
               rd_idx   = next_head;
            end else begin
               state_in = D_IDLE;
            end
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase

      if (wr_go) begin
         wr_en   = 1'b1;
         wr_idx  = slot_of(head_ff, wr_cnt);
         wr_ent  = '{pos: wr_p, val: wr_x};
         tail_in = wr_x;
         if (wr_cnt == CNT_FULL) begin
            // ring full: oldest entry is overwritten
            head_in    = next_head;
            count_in   = CNT_FULL;
            head_ok_in = 1'b0;
         end else begin
            count_in = wr_cnt + 1'b1;
            if (wr_cnt == '0) begin
               head_ent_in = '{pos: wr_p, val: wr_x};
               head_ok_in  = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_ff[wr_idx] <= wr_ent;
      end
      if (rd_en) begin
         rd_ff <= ring_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= D_IDLE;
         head_ff    <= '0;
         count_ff   <= '0;
         head_ok_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         count_ff   <= count_in;
         head_ok_ff <= head_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ent_ff <= head_ent_in;
      tail_ff     <= tail_in;
      x_ff        <= x_in;
      p_ff        <= p_in;
      now_ff      <= now_in;
      limit_ff    <= limit_in;
   end

endmodule

[hdl/sliding_window_min_max_envelope.sv]
// Top level: streaming lower/upper envelope over a sliding window of samples.
// Each accepted item is pushed into both deques; an item that emits a point expires stale
//   head entries and registers the point on rsp. Each tail pop that leaves entries behind,
//   head expiry or head reload adds one ring read. A last-flagged item emits its pending
//   points, plus expiries, and no new item is taken until the block is back in T_IDLE.
// Reset is synchronous; radius resets to 1, both deques come up empty, no clearing pass.
module sliding_window_min_max_envelope import swme_pkg::*; #(
   parameter int MAX_RADIUS  = 31,
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_lower,
   output logic signed [SAMPLE_W-1:0] rsp_upper,
   output logic                       rsp_end_of_series,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [RAD_W-1:0]           csr_radius
);

   localparam int PEND_W = $clog2(MAX_RADIUS + 2);
   localparam int LIM_W  = $clog2(2 * MAX_RADIUS + 1);
   localparam int CMP_W  = RAD_W + 1;
   localparam logic [RAD_W-1:0]  RAD_MAX  = RAD_W'(MAX_RADIUS);
   localparam logic [PEND_W-1:0] PEND_MAX = PEND_W'(MAX_RADIUS + 1);

   typedef enum logic [2:0] {
      T_IDLE  = 3'b001,
      T_EMIT  = 3'b010,
      T_FRONT = 3'b100
   } top_state_type;

   top_state_type               state_ff, state_in;
   logic [RAD_W-1:0]            radius_ff, radius_in;
   logic [POS_W-1:0]            seen_ff, seen_in;
   logic [PEND_W-1:0]           pend_ff, pend_in;
   logic                        last_ff, last_in;
   logic                        one_ff, one_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0]  rsp_lower_ff, rsp_upper_ff;
   logic                        rsp_eos_ff;

   logic                        req_accept, units_idle, rsp_free, rsp_load;
   logic                        want, front_go, finish;
   logic [PEND_W-1:0]           pend_inc, pend_dec;
   logic [LIM_W-1:0]            limit;
   logic                        min_busy, max_busy;
   logic signed [SAMPLE_W-1:0]  min_head, max_head;
   deque_cmd_type               dq_cmd;

   assign req_stall  = (state_ff != T_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign units_idle = !min_busy && !max_busy;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign pend_inc   = pend_ff + 1'b1;
   assign pend_dec   = pend_ff - 1'b1;
   assign limit      = LIM_W'(pend_dec) + LIM_W'(radius_ff);
   assign want       = last_ff ? (pend_ff != '0) : one_ff;

   assign dq_cmd.clear = finish && last_ff;
   assign dq_cmd.push  = req_accept;
   assign dq_cmd.front = front_go;

   assign radius_in = (csr_radius > RAD_MAX) ? RAD_MAX : csr_radius;

   always_comb begin
      state_in = state_ff;
      seen_in  = seen_ff;
      pend_in  = pend_ff;
      last_in  = last_ff;
      one_in   = one_ff;
      front_go = 1'b0;
      rsp_load = 1'b0;
      finish   = 1'b0;

      case (state_ff)
         T_IDLE: begin
            if (req_accept) begin
               pend_in  = pend_inc;
               last_in  = req_last;
               one_in   = CMP_W'(pend_inc) > CMP_W'(radius_ff);
               state_in = T_EMIT;
            end
         end
         T_EMIT: begin
            if (units_idle) begin
               if (want) begin
                  front_go = 1'b1;
                  state_in = T_FRONT;
               end else begin
                  finish = 1'b1;
               end
            end
         end
         T_FRONT: begin
            if (units_idle && rsp_free) begin
               rsp_load = 1'b1;
               pend_in  = pend_dec;
               one_in   = 1'b0;
               if (last_ff && pend_dec != '0) begin
                  state_in = T_EMIT;
               end else begin
                  finish = 1'b1;
               end
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase

      if (finish) begin
         state_in = T_IDLE;
         if (last_ff) begin
            seen_in = '0;
            pend_in = '0;
         end else begin
            seen_in = seen_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   swme_deque #(
      .DEPTH (QUEUE_DEPTH),
      .LIM_W (LIM_W)
   ) u_min_deque (
      .clock    (clock),
      .reset    (reset),
      .cmd      (dq_cmd),
      .push_val (req_sample),
      .push_pos (seen_ff),
      .now      (seen_ff),
      .limit    (limit),
      .busy     (min_busy),
      .head_val (min_head)
   );

   // max deque runs as a min deque over inverted samples
   swme_deque #(
      .DEPTH (QUEUE_DEPTH),
      .LIM_W (LIM_W)
   ) u_max_deque (
      .clock    (clock),
      .reset    (reset),
      .cmd      (dq_cmd),
      .push_val (~req_sample),
      .push_pos (seen_ff),
      .now      (seen_ff),
      .limit    (limit),
      .busy     (max_busy),
      .head_val (max_head)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         radius_ff    <= RAD_W'(1);
         seen_ff      <= '0;
         pend_ff      <= '0;
         last_ff      <= 1'b0;
         one_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         pend_ff      <= pend_in;
         last_ff      <= last_in;
         one_ff       <= one_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            radius_ff <= radius_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_lower_ff <= min_head;
         rsp_upper_ff <= ~max_head;
         rsp_eos_ff   <= last_ff && (pend_dec == '0);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_lower         = rsp_lower_ff;
   assign rsp_upper         = rsp_upper_ff;
   assign rsp_end_of_series = rsp_eos_ff;

`ifndef SYNTHESIS
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= PEND_MAX)
      else $error("pending point count out of range");

   a_idle_units: assert property (@(posedge clock) disable iff (reset)
      state_ff == T_IDLE |-> units_idle)
      else $error("deque busy while block idle");

   a_series_clear: assert property (@(posedge clock) disable iff (reset)
      finish && last_ff |=> seen_ff == '0 && pend_ff == '0)
      else $error("series not cleared after last item");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> rsp_free)
      else $error("result register overwritten while held");
`endif

endmodule
